// File: src/rx_byte_ring_fifo_peek_discard_macros.svh
// ----------------------------------------------------------------------------
// rx byte ring fifo assertion macros
// shared assertion shorthands for the receive fifo checker
// ----------------------------------------------------------------------------
`ifndef RX_BYTE_RING_FIFO_PEEK_DISCARD_MACROS_SVH
`define RX_BYTE_RING_FIFO_PEEK_DISCARD_MACROS_SVH

// clocked assertion, switched off while reset is held
`define RBF_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion that also holds during reset
`define RBF_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/rbf_pkg.sv
// ----------------------------------------------------------------------------
// rbf_pkg
// types and constants shared by the receive byte fifo modules
// ----------------------------------------------------------------------------
package rbf_pkg;

    // default store depth in bytes
    localparam int RBF_DEPTH = 1024;

    // request field widths
    localparam int ACTION_W = 3;
    localparam int BYTE_W   = 8;
    localparam int AMOUNT_W = 11;
    localparam int FILL_W   = 11;

    // packed stream widths (padded to whole bytes)
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    // action codes
    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH    = 3'd0,
        ACT_POP     = 3'd1,
        ACT_PEEK    = 3'd2,
        ACT_DISCARD = 3'd3,
        ACT_CLEAR   = 3'd4
    } rbf_action_t;

    // result of one request, known at acceptance except the read byte
    typedef struct packed {
        logic              rd;    // byte comes from the store
        logic              ok;
        logic [FILL_W-1:0] fill;
    } rbf_resp_t;

endpackage

// File: src/rbf_ram.sv
// ----------------------------------------------------------------------------
// rbf_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module rbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // read port, output holds until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/rbf_ctrl.sv
// ----------------------------------------------------------------------------
// rbf_ctrl
// read/write indices, fill count and store access for each request
// ----------------------------------------------------------------------------
module rbf_ctrl import rbf_pkg::*; #(
    parameter int DEPTH = RBF_DEPTH
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     accept,
    input  logic [ACTION_W-1:0]      action,
    input  logic [AMOUNT_W-1:0]      amount,
    output logic                     mem_we,
    output logic [$clog2(DEPTH)-1:0] mem_waddr,
    output logic                     mem_re,
    output logic [$clog2(DEPTH)-1:0] mem_raddr,
    output rbf_resp_t                resp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = AW + 1;
    localparam int WW = (CW > AMOUNT_W) ? CW : AMOUNT_W;

    logic [AW-1:0] rd_idx_reg, rd_idx_next;
    logic [AW-1:0] wr_idx_reg, wr_idx_next;
    logic [CW-1:0] count_reg, count_next;

    logic          full, empty, amt_below;
    logic [CW-1:0] drop_n;
    logic [SW-1:0] off_sum, drop_sum;
    logic [AW-1:0] peek_addr, drop_idx, wr_inc, rd_inc;

    // status of the held bytes
    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);
    assign amt_below = (WW'(amount) < WW'(count_reg));
    assign drop_n    = amt_below ? CW'(amount) : count_reg;

    // wrapped index arithmetic, the sums in use stay below twice the depth
    always_comb begin
        off_sum  = SW'(rd_idx_reg) + SW'(amount);
        drop_sum = SW'(rd_idx_reg) + SW'(drop_n);
        peek_addr = (off_sum  >= SW'(DEPTH)) ? AW'(off_sum  - SW'(DEPTH)) : AW'(off_sum);
        drop_idx  = (drop_sum >= SW'(DEPTH)) ? AW'(drop_sum - SW'(DEPTH)) : AW'(drop_sum);
        wr_inc = (wr_idx_reg == AW'(DEPTH - 1)) ? '0 : wr_idx_reg + 1'b1;
        rd_inc = (rd_idx_reg == AW'(DEPTH - 1)) ? '0 : rd_idx_reg + 1'b1;
    end

    // decode the request
    always_comb begin
        rd_idx_next = rd_idx_reg;
        wr_idx_next = wr_idx_reg;
        count_next  = count_reg;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_raddr   = rd_idx_reg;
        resp.rd     = 1'b0;
        resp.ok     = 1'b0;
        case (action)
            ACT_PUSH: begin
                if (!full) begin
                    mem_we      = accept;
                    wr_idx_next = wr_inc;
                    count_next  = count_reg + 1'b1;
                    resp.ok     = 1'b1;
                end
            end
            ACT_POP: begin
                if (!empty) begin
                    mem_re      = accept;
                    rd_idx_next = rd_inc;
                    count_next  = count_reg - 1'b1;
                    resp.rd     = 1'b1;
                    resp.ok     = 1'b1;
                end
            end
            ACT_PEEK: begin
                if (amt_below) begin
                    mem_re    = accept;
                    mem_raddr = peek_addr;
                    resp.rd   = 1'b1;
                    resp.ok   = 1'b1;
                end
            end
            ACT_DISCARD: begin
                rd_idx_next = drop_idx;
                count_next  = count_reg - drop_n;
                resp.ok     = 1'b1;
            end
            ACT_CLEAR: begin
                rd_idx_next = '0;
                wr_idx_next = '0;
                count_next  = '0;
                resp.ok     = 1'b1;
            end
            default: begin
            end
        endcase
        resp.fill = FILL_W'(count_next);
    end

    assign mem_waddr = wr_idx_reg;

    // pointer and count registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_idx_reg <= '0;
            wr_idx_reg <= '0;
            count_reg  <= '0;
        end else if (accept) begin
            rd_idx_reg <= rd_idx_next;
            wr_idx_reg <= wr_idx_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: src/rx_byte_ring_fifo_peek_discard.sv
// ----------------------------------------------------------------------------
// rx_byte_ring_fifo_peek_discard
// circular receive byte fifo with push, pop, peek, discard and clear requests
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  s_axis    in         action, data_in, amount
//  m_axis    out        read_data, ok, fill_level
//
//  one request per cycle is taken while the result side keeps up
//  each result passes through the store read stage and then the output
//  register
//  pointers and count update in the cycle of acceptance, so requests chain
//  with no interlock; at most one store access per request sets the rate
//  reset empties the fifo at once; the byte store itself is not cleared
//  a stall on m_axis holds the result and backs up into s_tready
// ----------------------------------------------------------------------------
module rx_byte_ring_fifo_peek_discard import rbf_pkg::*; #(
    parameter int DEPTH = RBF_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // action[2:0], data_in[10:3], amount[21:11]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // read_data[7:0], ok[8], fill_level[19:9]
);

    localparam int AW = $clog2(DEPTH);

    logic [ACTION_W-1:0] action;
    logic [BYTE_W-1:0]   data_in;
    logic [AMOUNT_W-1:0] amount;

    logic          accept, advance;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [BYTE_W-1:0] mem_rdata;
    rbf_resp_t     resp;

    logic      st1_valid_reg, st1_valid_next;
    rbf_resp_t st1_resp_reg;
    logic      out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_data_reg;
    logic              out_ok_reg;
    logic [FILL_W-1:0] out_fill_reg;

    // unpack the request
    assign action  = s_tdata[ACTION_W-1:0];
    assign data_in = s_tdata[ACTION_W +: BYTE_W];
    assign amount  = s_tdata[ACTION_W+BYTE_W +: AMOUNT_W];

    // handshake
    assign advance  = st1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !st1_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    rbf_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .action   (action),
        .amount   (amount),
        .mem_we   (mem_we),
        .mem_waddr(mem_waddr),
        .mem_re   (mem_re),
        .mem_raddr(mem_raddr),
        .resp     (resp)
    );

    rbf_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(DEPTH)
    ) u_store (
        .aclk (aclk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(data_in),
        .re   (mem_re),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    // valid flags of the read stage and the output register
    always_comb begin
        st1_valid_next = st1_valid_reg;
        if (accept) begin
            st1_valid_next = 1'b1;
        end else if (advance) begin
            st1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            st1_valid_reg <= st1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload of the read stage and the output register
    always_ff @(posedge aclk) begin
        if (accept) begin
            st1_resp_reg <= resp;
        end
        if (advance) begin
            out_data_reg <= st1_resp_reg.rd ? mem_rdata : '0;
            out_ok_reg   <= st1_resp_reg.ok;
            out_fill_reg <= st1_resp_reg.fill;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - BYTE_W - 1 - FILL_W){1'b0}},
                       out_fill_reg, out_ok_reg, out_data_reg};

endmodule

// File: src/rbf_checker.sv
// ----------------------------------------------------------------------------
// rbf_checker
// port-level checks of the receive byte fifo results
// ----------------------------------------------------------------------------
`include "rx_byte_ring_fifo_peek_discard_macros.svh"

module rbf_checker import rbf_pkg::*; #(
    parameter int DEPTH = RBF_DEPTH
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    logic [BYTE_W-1:0] chk_data;
    logic              chk_ok;
    logic [FILL_W-1:0] chk_fill;
    logic              req_wait, res_wait, byte_shown, fill_ok;

    assign chk_data = m_tdata[BYTE_W-1:0];
    assign chk_ok   = m_tdata[BYTE_W];
    assign chk_fill = m_tdata[BYTE_W+1 +: FILL_W];

    // stall and range conditions seen on the ports
    assign req_wait   = s_tvalid && !s_tready;
    assign res_wait   = m_tvalid && !m_tready;
    assign byte_shown = m_tvalid && (chk_data != '0);
    assign fill_ok    = (DEPTH > 2047) || (chk_fill <= FILL_W'(DEPTH));

    // a waiting request stays put until taken
    `RBF_ASSERT(a_req, aclk, aresetn, req_wait |=> s_tvalid && $stable(s_tdata), "request not held")

    // a result waits until taken
    `RBF_ASSERT(a_hold, aclk, aresetn, res_wait |=> m_tvalid, "result dropped while stalled")

    // a byte only comes back from a request that succeeded
    `RBF_ASSERT(a_data_ok, aclk, aresetn, byte_shown |-> chk_ok, "byte on failed request")

    // fill level never exceeds the store depth
    `RBF_ASSERT(a_fill, aclk, aresetn, m_tvalid |-> fill_ok, "fill level above depth")

    // nothing leaves the block right after reset
    `RBF_ASSERT_ALWAYS(a_reset, aclk, !aresetn |=> !m_tvalid, "result shown after reset")

endmodule

bind rx_byte_ring_fifo_peek_discard rbf_checker #(.DEPTH(DEPTH)) u_rbf_checker (.*);
